// ===== rtl/mfbp_pkg.sv =====
// Shared types, constants and codes of the MSB-first bit packer.
package mfbp_pkg;

    // Fixed field widths of the item ports.
    localparam int VALUE_W    = 32;
    localparam int BITS_W     = 6;
    localparam int CAP_W      = 13;
    localparam int INDEX_W    = 12;
    localparam int BYTE_W     = 8;
    localparam int USED_W     = 4;

    // Default buffer size and reset capacity.
    localparam int BUFFER_BYTES_DEF = 4096;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd4096;

    // Widest field that one write places; wider requests saturate.
    localparam int MAX_FIELD_BITS = 32;
    localparam int LEN_W          = $clog2(MAX_FIELD_BITS + 1);
    localparam int ALIGN_W        = MAX_FIELD_BITS;

    // Bit count that marks "no open byte".
    localparam logic [USED_W-1:0] NO_OPEN_BYTE = 4'd8;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Action codes of an input item.
    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [VALUE_W-1:0] field_value;
        logic [BITS_W-1:0]  field_bits;
    } in_item_t;

    typedef struct packed {
        logic               byte_valid;
        logic [INDEX_W-1:0] byte_index;
        logic [BYTE_W-1:0]  byte_value;
        logic               status;
        logic               last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_BEGIN,
        CMD_WRITE,
        CMD_REFUSE
    } cmd_kind_t;

    // One classified item: the field is left aligned so its first bit is the MSB.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [ALIGN_W-1:0] aligned;
        logic [LEN_W-1:0]   len;
    } cmd_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WRITE,
        BK_REFUSE
    } back_state_t;

endpackage

// ===== rtl/mfbp_front.sv =====
// Front end: accepts input items, classifies them and aligns the field.
module mfbp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mfbp_pkg::in_item_t in_item,
    input  logic              queue_full,
    output logic              push,
    output mfbp_pkg::cmd_t    push_cmd
);

    logic                           write_enabled_reg;
    logic                           write_enabled_next;
    logic [mfbp_pkg::LEN_W-1:0]     len;
    logic [mfbp_pkg::LEN_W-1:0]     shift;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        if (32'(in_item.field_bits) > mfbp_pkg::MAX_FIELD_BITS)
        begin
            len = mfbp_pkg::LEN_W'(mfbp_pkg::MAX_FIELD_BITS);
        end
        else
        begin
            len = mfbp_pkg::LEN_W'(in_item.field_bits);
        end
        shift = mfbp_pkg::LEN_W'(mfbp_pkg::MAX_FIELD_BITS) - len;

        push_cmd.len     = len;
        push_cmd.aligned = mfbp_pkg::ALIGN_W'(in_item.field_value) << shift;
        if (in_item.action == mfbp_pkg::ACT_BEGIN)
        begin
            push_cmd.kind = mfbp_pkg::CMD_BEGIN;
        end
        else if (!write_enabled_reg)
        begin
            push_cmd.kind = mfbp_pkg::CMD_REFUSE;
        end
        else
        begin
            push_cmd.kind = mfbp_pkg::CMD_WRITE;
        end

        write_enabled_next = write_enabled_reg;
        if (push && in_item.action == mfbp_pkg::ACT_BEGIN)
        begin
            write_enabled_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_enabled_reg <= 1'b0;
        end
        else
        begin
            write_enabled_reg <= write_enabled_next;
        end
    end

endmodule

// ===== rtl/mfbp_queue.sv =====
// Short command queue between the front end and the back end.
module mfbp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mfbp_pkg::cmd_t        push_cmd,
    output logic                  full,
    input  logic                  pop,
    output mfbp_pkg::queue_head_t head
);

    localparam int DEPTH = mfbp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfbp_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/mfbp_back.sv =====
// Back end: carries out commands, one output byte per cycle while the receiver does not stall.
module mfbp_back #(
    parameter int BUFFER_BYTES = mfbp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mfbp_pkg::CAP_W-1:0]  capacity,
    input  mfbp_pkg::queue_head_t       head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output mfbp_pkg::out_item_t         out_item
);

    localparam int IDX_W = $clog2(BUFFER_BYTES + 1);

    mfbp_pkg::back_state_t             state_reg;
    mfbp_pkg::back_state_t             state_next;
    logic [IDX_W-1:0]                  idx_reg;
    logic [IDX_W-1:0]                  idx_next;
    logic [mfbp_pkg::USED_W-1:0]       used_reg;
    logic [mfbp_pkg::USED_W-1:0]       used_next;
    logic [mfbp_pkg::BYTE_W-1:0]       open_reg;
    logic [mfbp_pkg::BYTE_W-1:0]       open_next;
    logic                              err_reg;
    logic                              err_next;
    logic [mfbp_pkg::ALIGN_W-1:0]      aligned_reg;
    logic [mfbp_pkg::ALIGN_W-1:0]      aligned_next;
    logic [mfbp_pkg::LEN_W-1:0]        len_reg;
    logic [mfbp_pkg::LEN_W-1:0]        len_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    mfbp_pkg::out_item_t               out_item_reg;
    mfbp_pkg::out_item_t               out_item_next;

    logic [IDX_W-1:0]                  cap;
    logic                              can_emit;
    logic                              byte_open;
    logic [mfbp_pkg::USED_W-1:0]       used_eff;
    logic [mfbp_pkg::BYTE_W-1:0]       open_eff;
    logic [mfbp_pkg::USED_W-1:0]       avail;
    logic [mfbp_pkg::USED_W-1:0]       take;
    logic [mfbp_pkg::BYTE_W-1:0]       open_new;
    logic [mfbp_pkg::LEN_W-1:0]        len_new;
    logic [IDX_W-1:0]                  byte_idx;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Effective capacity, clipped to the buffer size.
    always_comb
    begin
        if (32'(capacity) > BUFFER_BYTES)
        begin
            cap = IDX_W'(BUFFER_BYTES);
        end
        else
        begin
            cap = IDX_W'(capacity);
        end
    end

    // Placement of the next chunk into the current or a fresh byte.
    always_comb
    begin
        byte_open = (used_reg != mfbp_pkg::NO_OPEN_BYTE);
        used_eff  = byte_open ? used_reg : '0;
        open_eff  = byte_open ? open_reg : '0;
        avail     = mfbp_pkg::USED_W'(mfbp_pkg::BYTE_W) - used_eff;
        if (mfbp_pkg::LEN_W'(avail) < len_reg)
        begin
            take = avail;
        end
        else
        begin
            take = mfbp_pkg::USED_W'(len_reg);
        end
        // Bits below the field are zero, so the top byte shifted by the fill is the chunk.
        open_new = open_eff
                 | (aligned_reg[mfbp_pkg::ALIGN_W-1 -: mfbp_pkg::BYTE_W] >> used_eff);
        len_new  = len_reg - mfbp_pkg::LEN_W'(take);
        byte_idx = byte_open ? idx_reg - 1'b1 : idx_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        open_next      = open_reg;
        err_next       = err_reg;
        aligned_next   = aligned_reg;
        len_next       = len_reg;
        pop            = 1'b0;
        can_emit       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            mfbp_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    unique case (head.cmd.kind)
                        mfbp_pkg::CMD_BEGIN:
                        begin
                            idx_next  = '0;
                            used_next = mfbp_pkg::NO_OPEN_BYTE;
                            open_next = '0;
                            err_next  = 1'b0;
                        end
                        mfbp_pkg::CMD_WRITE:
                        begin
                            aligned_next = head.cmd.aligned;
                            len_next     = head.cmd.len;
                            state_next   = mfbp_pkg::BK_WRITE;
                        end
                        mfbp_pkg::CMD_REFUSE:
                        begin
                            state_next = mfbp_pkg::BK_REFUSE;
                        end
                        default:
                        begin
                            state_next = mfbp_pkg::BK_IDLE;
                        end
                    endcase
                end
            end

            mfbp_pkg::BK_REFUSE:
            begin
                if (can_emit)
                begin
                    err_next                 = 1'b1;
                    out_valid_next           = 1'b1;
                    out_item_next.byte_valid = 1'b0;
                    out_item_next.byte_index = '0;
                    out_item_next.byte_value = '0;
                    out_item_next.status     = 1'b1;
                    out_item_next.last       = 1'b1;
                    state_next               = mfbp_pkg::BK_IDLE;
                end
            end

            mfbp_pkg::BK_WRITE:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    if (len_reg == '0)
                    begin
                        out_item_next.byte_valid = 1'b0;
                        out_item_next.byte_index = '0;
                        out_item_next.byte_value = '0;
                        out_item_next.status     = err_reg;
                        out_item_next.last       = 1'b1;
                        state_next               = mfbp_pkg::BK_IDLE;
                    end
                    else if (!byte_open && idx_reg >= cap)
                    begin
                        err_next                 = 1'b1;
                        out_item_next.byte_valid = 1'b0;
                        out_item_next.byte_index = '0;
                        out_item_next.byte_value = '0;
                        out_item_next.status     = 1'b1;
                        out_item_next.last       = 1'b1;
                        state_next               = mfbp_pkg::BK_IDLE;
                    end
                    else
                    begin
                        if (!byte_open)
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                        used_next                = used_eff + take;
                        open_next                = open_new;
                        len_next                 = len_new;
                        aligned_next             = aligned_reg << take;
                        out_item_next.byte_valid = 1'b1;
                        out_item_next.byte_index = mfbp_pkg::INDEX_W'(byte_idx);
                        out_item_next.byte_value = open_new;
                        out_item_next.status     = err_reg;
                        out_item_next.last       = (len_new == '0);
                        if (len_new == '0)
                        begin
                            state_next = mfbp_pkg::BK_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = mfbp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfbp_pkg::BK_IDLE;
            idx_reg       <= '0;
            used_reg      <= mfbp_pkg::NO_OPEN_BYTE;
            open_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            open_reg      <= open_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aligned_reg  <= aligned_next;
        len_reg      <= len_next;
        out_item_reg <= out_item_next;
    end

endmodule

// ===== rtl/msb_first_bit_packer_core.sv =====
// Top level of the MSB-first bit packer.
//
// The packer writes bit fields, most significant bit first, into consecutive
// bytes of a buffer. Input items arrive on in_valid/in_stall/in_item: a begin
// item opens a new packet; a write item places the low field_bits bits of
// field_value. Every byte a write touches comes out as one item on
// out_valid/out_stall/out_item with its index and current value; a partly
// filled byte is sent again as it fills. A write with no byte to show, a write
// before begin, or a write that runs past the capacity ends with an item whose
// byte_valid is low. The item that closes a write carries last.
// An item is taken when valid is high and stall is low, on either side.
// The capacity register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce. The
// first result of a write passes through the command queue, the back end's
// write state and its output register. The back end starts a write from idle
// and then gives one result per cycle while the receiver does not stall.
// Reset clears the packet state, disables writing until a begin, and sets the
// capacity to 4096 bytes. When the receiver stalls, the output item holds,
// the back end waits, and the two-entry command queue keeps taking items
// until it is full.
module msb_first_bit_packer_core #(
    parameter int BUFFER_BYTES = mfbp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  mfbp_pkg::in_item_t         in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output mfbp_pkg::out_item_t        out_item,
    input  logic                       cfg_we,
    input  logic [mfbp_pkg::CAP_W-1:0] cfg_wdata
);

    logic [mfbp_pkg::CAP_W-1:0] capacity_reg;
    logic [mfbp_pkg::CAP_W-1:0] capacity_next;
    logic                       queue_full;
    logic                       push;
    mfbp_pkg::cmd_t             push_cmd;
    logic                       pop;
    mfbp_pkg::queue_head_t      head;

    // The capacity register is the only configuration state.
    assign capacity_next = cfg_we ? cfg_wdata : capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= mfbp_pkg::CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // The front end classifies each item and left-aligns the field.
    mfbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // The queue lets the front keep accepting while the back end is busy.
    mfbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head)
    );

    // The back end owns the packet state and drives the output register.
    mfbp_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ===== rtl/mfbp_checker.sv =====
// Port-level assertions for the MSB-first bit packer, bound to its top level.
module mfbp_port_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input mfbp_pkg::out_item_t out_item
);

    logic                            in_write_reg;
    logic                            prev_valid_reg;
    logic                            prev_status_reg;
    logic [mfbp_pkg::INDEX_W-1:0]    prev_index_reg;
    logic                            out_take;

    assign out_take = out_valid && !out_stall;

    // Track the last accepted result and whether its write has more results to come.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_write_reg    <= 1'b0;
            prev_valid_reg  <= 1'b0;
            prev_status_reg <= 1'b0;
            prev_index_reg  <= '0;
        end
        else if (out_take)
        begin
            in_write_reg    <= !out_item.last;
            prev_valid_reg  <= out_item.byte_valid;
            prev_status_reg <= out_item.status;
            prev_index_reg  <= out_item.byte_index;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    a_no_byte_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.byte_valid |->
            out_item.last && out_item.byte_index == '0 && out_item.byte_value == '0)
        else $error("result without a byte is not a clean final item");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_write_reg && prev_status_reg |-> out_item.status)
        else $error("error status dropped within a write");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_write_reg && prev_valid_reg && out_item.byte_valid |->
            out_item.byte_index == prev_index_reg ||
            out_item.byte_index == prev_index_reg + 1'b1)
        else $error("byte index jumped within a write");

endmodule

bind msb_first_bit_packer_core mfbp_port_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
